// File: src/rrd_pkg.sv
// Shared types and constants for the RLE row decoder.
`timescale 1ns / 1ps

package rrd_pkg;

  localparam logic [1:0] PHASE_CTRL = 2'd0;
  localparam logic [1:0] PHASE_LIT  = 2'd1;
  localparam logic [1:0] PHASE_RUN  = 2'd2;

  localparam int unsigned LITERAL_BIT   = 7;
  localparam logic [15:0] ROW_WIDTH_RST = 16'd256;

  typedef struct packed {
    logic [1:0]  phase;
    logic [6:0]  remaining;
    logic [15:0] column;
  } state_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [6:0]  repeat_count;
    logic [15:0] start_column;
    logic        end_of_row;
    logic        overrun;
    logic        short_row;
  } result_t;

endpackage

// File: src/rrd_step.sv
// Per-byte decode: next decoder state and the result beat, if any.
`timescale 1ns / 1ps

module rrd_step (
  input  rrd_pkg::state_t  st,
  input  logic [7:0]       in_byte,
  input  logic [15:0]      row_width,
  output rrd_pkg::state_t  st_nxt,
  output rrd_pkg::result_t res,
  output logic             res_valid
);

  logic [15:0] room;
  logic [6:0]  n;
  logic [6:0]  kept;
  logic [6:0]  count;

  assign count = in_byte[6:0];
  assign room  = (st.column < row_width) ? (row_width - st.column) : 16'd0;
  assign n     = (st.phase == rrd_pkg::PHASE_LIT) ? 7'd1 : st.remaining;
  assign kept  = ({9'd0, n} < room) ? n : room[6:0];

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res       = '0;
    case (st.phase)
      rrd_pkg::PHASE_LIT, rrd_pkg::PHASE_RUN: begin
        res_valid        = 1'b1;
        res.pixel_value  = in_byte;
        res.repeat_count = kept;
        res.start_column = st.column;
        res.overrun      = (kept < n);
        st_nxt.column    = st.column + {9'd0, kept};
        if (st.phase == rrd_pkg::PHASE_LIT) begin
          st_nxt.remaining = st.remaining - 7'd1;
          if (st_nxt.remaining == 7'd0) begin
            st_nxt.phase = rrd_pkg::PHASE_CTRL;
          end
        end else begin
          st_nxt.remaining = 7'd0;
          st_nxt.phase     = rrd_pkg::PHASE_CTRL;
        end
      end
      default: begin
        if (count == 7'd0) begin
          res_valid        = 1'b1;
          res.start_column = st.column;
          res.end_of_row   = 1'b1;
          res.short_row    = (st.column < row_width);
          st_nxt.column    = 16'd0;
          st_nxt.remaining = 7'd0;
          st_nxt.phase     = rrd_pkg::PHASE_CTRL;
        end else begin
          st_nxt.remaining = count;
          st_nxt.phase     = in_byte[rrd_pkg::LITERAL_BIT] ? rrd_pkg::PHASE_LIT
                                                           : rrd_pkg::PHASE_RUN;
        end
      end
    endcase
  end

endmodule

// File: src/rle_row_decoder_unit.sv
// Top level of the RLE row decoder: input stage, decode, result register.
// Takes one compressed byte per cycle and keeps that rate as long as the
// result side takes its beats. A byte is held in the input register, is
// decoded there against the row state, and its result (if it makes one) is
// loaded into the result register that drives the result port. Control
// bytes with a nonzero count update state and produce no result beat. When
// the result register is full and not taken, bytes that make results wait in
// the input register; the stream then advances at the rate results are taken.
`timescale 1ns / 1ps

module rle_row_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_value,
  output logic [6:0]  out_repeat_count,
  output logic [15:0] out_start_column,
  output logic        out_end_of_row,
  output logic        out_overrun,
  output logic        out_short_row
);

  logic [15:0]      row_width_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  rrd_pkg::state_t  state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  rrd_pkg::result_t out_res_r;
  rrd_pkg::result_t res;
  logic             res_valid;
  logic             out_free, advance, out_load, in_fire;

  rrd_step u_step (
    .st        (state_r),
    .in_byte   (s1_byte_r),
    .row_width (row_width_r),
    .st_nxt    (state_nxt),
    .res       (res),
    .res_valid (res_valid)
  );

  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && (!res_valid || out_free);
  assign out_load = advance && res_valid;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= rrd_pkg::ROW_WIDTH_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: rrd_pkg::PHASE_CTRL, remaining: 7'd0, column: 16'd0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        row_width_r <= cfg_wdata;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte;
    end
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_res_r.pixel_value;
  assign out_repeat_count = out_res_r.repeat_count;
  assign out_start_column = out_res_r.start_column;
  assign out_end_of_row   = out_res_r.end_of_row;
  assign out_overrun      = out_res_r.overrun;
  assign out_short_row    = out_res_r.short_row;

  // held byte is never dropped while the result side stalls
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("input stage lost a byte");

  // end marker restarts the row
  a_eor_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res.end_of_row) |=> (state_r.column == 16'd0))
    else $error("column not cleared after end marker");

  // end marker carries no pixels and no overrun
  a_eor_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.end_of_row) |->
      (out_res_r.repeat_count == 7'd0 && !out_res_r.overrun))
    else $error("end marker with pixel data");

  // short_row only on the end marker beat
  a_short_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.short_row) |-> out_res_r.end_of_row)
    else $error("short_row outside end marker");

  // a loaded result is presented the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule
